>>> hw/rtl/column_dictionary_encoder_macros.svh
// Assertion macros shared by the column dictionary encoder RTL.
`ifndef COLUMN_DICTIONARY_ENCODER_MACROS_SVH
`define COLUMN_DICTIONARY_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cde_pkg.sv
// Package: types, codes and constants of the column dictionary encoder.
`timescale 1ns / 1ps
package cde_pkg;

  localparam int DICT_DEPTH_DEF = 1024;
  localparam int VALUE_BITS_DEF = 64;

  // Multiplicative hash constant (golden ratio, 32 bit).
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam logic [2:0] STATUS_HIT      = 3'd0;
  localparam logic [2:0] STATUS_INSERTED = 3'd1;
  localparam logic [2:0] STATUS_NULL     = 3'd2;
  localparam logic [2:0] STATUS_FULL     = 3'd3;
  localparam logic [2:0] STATUS_RANGE    = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [63:0] row_value;
    logic        present;
    logic        last_row;
    logic [9:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [9:0]  code;
    logic [2:0]  status;
    logic [63:0] entry_value;
    logic [10:0] entries_used;
    logic        batch_end;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_CHECK,
    ST_RD_WAIT,
    ST_EMIT
  } state_t;

endpackage

>>> hw/rtl/cde_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module cde_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/column_dictionary_encoder.sv
// Top level of the column dictionary encoder: hash lookup, insert and read-out.
`timescale 1ns / 1ps
// Column dictionary encoder. Each item transfer on the item channel is either
// an encode of one row (mode 0) or a read of one stored entry by code
// (mode 1); each gives exactly one transfer on the result channel. Codes are
// handed out in insertion order, 0, 1, 2, ..., and the entry store holds the
// values in that order, so a read-out sweep over codes 0..entries_used-1
// yields the dictionary in serialization order. Lookup goes through an open
// addressing hash table (linear probing, table twice the dictionary depth
// rounded up to a power of two) kept in its own RAM next to the entry store.
// Steps: a present row passes accept, table read, one compare step per probe
// and result load; the hash table RAM read port does one probe per cycle.
// A read-mode item adds an entry store read; a null row or an out-of-range
// read goes from accept straight to result load. One item is in
// flight at a time; the result register lets the next item in while a
// finished result waits. After reset the block clears all
// 2^(clog2(DICT_DEPTH)+1) hash table slots (2048 at the default depth), one
// slot a cycle, and holds item_stall high meanwhile. A miss with the
// dictionary full reports status full and inserts nothing; code and
// entry_value are zero where none applies.
module column_dictionary_encoder #(
  parameter int DICT_DEPTH = cde_pkg::DICT_DEPTH_DEF,
  parameter int VALUE_BITS = cde_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  cde_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output cde_pkg::result_t result
);

  `include "column_dictionary_encoder_macros.svh"

  localparam int AW     = $clog2(DICT_DEPTH);      // entry store address / code
  localparam int TW     = AW + 1;                  // hash table address
  localparam int TBL    = 1 << TW;                 // hash table slots
  localparam int CNT_W  = $clog2(DICT_DEPTH + 1);  // entry count
  localparam int SLOT_W = 1 + VALUE_BITS + AW;     // {occupied, value, code}

  // Control state
  cde_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [TW-1:0]    clr_addr, clr_addr_next;
  logic             result_valid_next;

  // Item context and pending result
  logic [TW-1:0]         probe_addr, probe_addr_next;
  logic [VALUE_BITS-1:0] key, key_next;
  logic                  last_q, last_q_next;
  logic [AW-1:0]         res_code, res_code_next;
  logic [2:0]            res_status, res_status_next;
  logic [VALUE_BITS-1:0] res_entry, res_entry_next;
  cde_pkg::result_t      result_next;

  // Memory ports
  logic                  tbl_we;
  logic [TW-1:0]         tbl_waddr, tbl_raddr;
  logic [SLOT_W-1:0]     tbl_wdata, tbl_rdata;
  logic                  ent_we;
  logic [AW-1:0]         ent_waddr, ent_raddr;
  logic [VALUE_BITS-1:0] ent_wdata, ent_rdata;

  // Hash of the incoming value
  logic [VALUE_BITS-1:0] in_val;
  logic [63:0]           in_wide;
  logic [31:0]           hash_fold, hash_prod;
  logic [TW-1:0]         hash_addr;

  // Slot decode
  logic                  slot_occ;
  logic [VALUE_BITS-1:0] slot_val;
  logic [AW-1:0]         slot_code;

  logic accept, out_free, has_room, ins_fire;

  assign item_stall = (state != cde_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign has_room   = (32'(count) < 32'(DICT_DEPTH));

  assign in_val    = VALUE_BITS'(item.row_value);
  assign in_wide   = 64'(in_val);
  assign hash_fold = in_wide[63:32] ^ in_wide[31:0];
  assign hash_prod = hash_fold * cde_pkg::HASH_MULT;
  assign hash_addr = hash_prod[31 -: TW];

  assign slot_occ  = tbl_rdata[SLOT_W-1];
  assign slot_val  = tbl_rdata[AW +: VALUE_BITS];
  assign slot_code = tbl_rdata[AW-1:0];

  // Hash table: slot per value, probed linearly.
  cde_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TBL)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Entry store: values by code, insertion order.
  cde_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DICT_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  always_comb begin
    state_next        = state;
    count_next        = count;
    clr_addr_next     = clr_addr;
    probe_addr_next   = probe_addr;
    key_next          = key;
    last_q_next       = last_q;
    res_code_next     = res_code;
    res_status_next   = res_status;
    res_entry_next    = res_entry;
    result_next       = result;
    result_valid_next = result_valid && result_stall;
    ins_fire          = 1'b0;

    tbl_we    = 1'b0;
    tbl_waddr = probe_addr;
    tbl_wdata = {1'b1, key, AW'(count)};
    tbl_raddr = probe_addr;
    ent_we    = 1'b0;
    ent_waddr = AW'(count);
    ent_wdata = key;
    ent_raddr = AW'(item.read_index);

    case (state)
      cde_pkg::ST_CLEAR: begin
        // Empty every hash slot after reset.
        tbl_we        = 1'b1;
        tbl_waddr     = clr_addr;
        tbl_wdata     = '0;
        clr_addr_next = clr_addr + TW'(1);
        if (clr_addr == TW'(TBL - 1)) begin
          state_next = cde_pkg::ST_IDLE;
        end
      end

      cde_pkg::ST_IDLE: begin
        if (accept) begin
          key_next        = in_val;
          last_q_next     = item.last_row;
          probe_addr_next = hash_addr;
          res_code_next   = '0;
          res_entry_next  = '0;
          if (item.mode == cde_pkg::MODE_READ) begin
            // Entry store read issued here; data next cycle.
            if (32'(item.read_index) < 32'(count)) begin
              res_code_next = AW'(item.read_index);
              state_next    = cde_pkg::ST_RD_WAIT;
            end else begin
              res_status_next = cde_pkg::STATUS_RANGE;
              state_next      = cde_pkg::ST_EMIT;
            end
          end else if (!item.present) begin
            res_status_next = cde_pkg::STATUS_NULL;
            state_next      = cde_pkg::ST_EMIT;
          end else begin
            state_next = cde_pkg::ST_ISSUE;
          end
        end
      end

      cde_pkg::ST_ISSUE: begin
        tbl_raddr  = probe_addr;
        state_next = cde_pkg::ST_CHECK;
      end

      cde_pkg::ST_CHECK: begin
        if (slot_occ && (slot_val == key)) begin
          res_code_next   = slot_code;
          res_status_next = cde_pkg::STATUS_HIT;
          state_next      = cde_pkg::ST_EMIT;
        end else if (!slot_occ) begin
          // Empty slot ends the probe: value is new.
          if (has_room) begin
            ins_fire        = 1'b1;
            tbl_we          = 1'b1;
            tbl_waddr       = probe_addr;
            ent_we          = 1'b1;
            count_next      = count + CNT_W'(1);
            res_code_next   = AW'(count);
            res_status_next = cde_pkg::STATUS_INSERTED;
          end else begin
            res_status_next = cde_pkg::STATUS_FULL;
          end
          state_next = cde_pkg::ST_EMIT;
        end else begin
          // Collision: read the next slot, stay here.
          probe_addr_next = probe_addr + TW'(1);
          tbl_raddr       = probe_addr + TW'(1);
        end
      end

      cde_pkg::ST_RD_WAIT: begin
        res_entry_next  = ent_rdata;
        res_status_next = cde_pkg::STATUS_HIT;
        state_next      = cde_pkg::ST_EMIT;
      end

      cde_pkg::ST_EMIT: begin
        if (out_free) begin
          result_next.code         = 10'(res_code);
          result_next.status       = res_status;
          result_next.entry_value  = 64'(res_entry);
          result_next.entries_used = 11'(count);
          result_next.batch_end    = last_q;
          result_valid_next        = 1'b1;
          state_next               = cde_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = cde_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cde_pkg::ST_CLEAR;
      count        <= '0;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      clr_addr     <= clr_addr_next;
      result_valid <= result_valid_next;
    end
    probe_addr <= probe_addr_next;
    key        <= key_next;
    last_q     <= last_q_next;
    res_code   <= res_code_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    result     <= result_next;
  end

  `CDE_ASSERT_IMPL(a_count_bound, 1'b1, 32'(count) <= 32'(DICT_DEPTH),
                   "entry count above dictionary depth")
  `CDE_ASSERT_NEXT(a_insert_count, ins_fire, count == $past(count) + CNT_W'(1),
                   "insert did not advance entry count")
  `CDE_ASSERT_IMPL(a_insert_code,
                   result_valid && (result.status == cde_pkg::STATUS_INSERTED),
                   result.entries_used[9:0] == result.code + 10'd1,
                   "inserted code does not match entry count")

endmodule

>>> test/testbench.sv
// Self-checking testbench for the column dictionary encoder: directed and random transfers.
`timescale 1ns / 1ps
module testbench;

  localparam int   DEPTH     = cde_pkg::DICT_DEPTH_DEF;
  localparam int   PHASE_LEN = 212;
  localparam int   TAIL_WAIT = 50;
  localparam logic ENC       = cde_pkg::MODE_ENCODE;
  localparam logic RD        = cde_pkg::MODE_READ;

  // Tracks the dictionary contents and the queue of results still owed.
  class dict_scoreboard;
    logic [63:0]      entries [DEPTH];
    int unsigned      code_of [bit [63:0]];
    int unsigned      used;
    cde_pkg::result_t owed [$];
    int               errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void note_item(cde_pkg::item_t it);
      cde_pkg::result_t want;
      bit [63:0] v;
      want = '0;
      v = it.row_value;
      want.batch_end = it.last_row;
      if (it.mode == cde_pkg::MODE_READ) begin
        if (it.read_index < used) begin
          want.code = it.read_index;
          want.entry_value = entries[it.read_index];
          want.status = cde_pkg::STATUS_HIT;
        end else begin
          want.status = cde_pkg::STATUS_RANGE;
        end
      end else if (!it.present) begin
        want.status = cde_pkg::STATUS_NULL;
      end else if (code_of.exists(v)) begin
        want.code = 10'(code_of[v]);
        want.status = cde_pkg::STATUS_HIT;
      end else if (used < DEPTH) begin
        entries[used] = v;
        code_of[v] = used;
        want.code = 10'(used);
        want.status = cde_pkg::STATUS_INSERTED;
        used++;
      end else begin
        want.status = cde_pkg::STATUS_FULL;
      end
      want.entries_used = 11'(used);
      owed = {owed, want};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(cde_pkg::result_t got);
      cde_pkg::result_t want;
      if (owed.size() == 0) begin
        report("unexpected result", 64'(got.code), '0);
      end else begin
        want = owed.pop_front();
        if (got.code !== want.code) report("code", 64'(got.code), 64'(want.code));
        if (got.status !== want.status)
          report("status", 64'(got.status), 64'(want.status));
        if (got.entry_value !== want.entry_value)
          report("entry_value", got.entry_value, want.entry_value);
        if (got.entries_used !== want.entries_used)
          report("entries_used", 64'(got.entries_used), 64'(want.entries_used));
        if (got.batch_end !== want.batch_end)
          report("batch_end", 64'(got.batch_end), 64'(want.batch_end));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  cde_pkg::item_t   item_data;
  logic             result_valid;
  logic             result_stall;
  cde_pkg::result_t result_data;

  int      stall_pct;
  dict_scoreboard sb;

  column_dictionary_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_data)
  );

  always #2 clk = ~clk;

  // Receiver backpressure, changed on the falling edge only.
  always @(negedge clk) begin
    if (rst) result_stall <= 1'b0;
    else     result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Both channels sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0)
      sb.check_result(result_data);
    if (!rst && item_valid === 1'b1 && item_stall === 1'b0)
      sb.note_item(item_data);
  end

  function automatic cde_pkg::item_t make_item(logic mode, logic [63:0] value, logic present,
                                               logic last, logic [9:0] idx);
    cde_pkg::item_t it;
    it.mode = mode;
    it.row_value = value;
    it.present = present;
    it.last_row = last;
    it.read_index = idx;
    return it;
  endfunction

  // Called and returning at a falling edge; holds the payload until transfer.
  task automatic send_item(input cde_pkg::item_t it, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item_data <= it;
    do @(posedge clk); while (item_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Sender holds off until every owed result has been taken.
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [63:0]    sent_vals [$];
    logic [63:0]    v;
    cde_pkg::item_t it;
    int             idle_pct;
    int             r;
    int             new_pct;

    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item_data = '0;
    stall_pct = 0;
    idle_pct = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, hit, insert, null, reads in and out of range.
    send_item(make_item(ENC, 64'h0, 1'b1, 1'b1, 10'h3FF), 0);
    send_item(make_item(ENC, '1, 1'b1, 1'b0, 10'h0), 0);
    send_item(make_item(ENC, 64'h0, 1'b1, 1'b0, 10'h155), 0);
    send_item(make_item(ENC, '1, 1'b0, 1'b1, 10'h3FF), 0);
    send_item(make_item(ENC, 64'h0, 1'b0, 1'b0, 10'h0), 0);
    send_item(make_item(RD, '1, 1'b0, 1'b0, 10'd0), 0);
    send_item(make_item(RD, 64'h0, 1'b1, 1'b1, 10'd1), 0);
    send_item(make_item(RD, '1, 1'b1, 1'b0, 10'd2), 0);
    send_item(make_item(RD, 64'h0, 1'b0, 1'b1, 10'h3FF), 0);
    send_item(make_item(ENC, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 10'h2AA), 0);
    send_item(make_item(ENC, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 10'h155), 0);
    send_item(make_item(ENC, '1, 1'b1, 1'b0, 10'h0), 0);
    send_item(make_item(ENC, 64'h8000_0000_0000_0001, 1'b1, 1'b0, 10'h0), 0);
    send_item(make_item(ENC, 64'h8000_0000_0000_0001, 1'b1, 1'b0, 10'h0), 0);
    send_item(make_item(RD, 64'h0, 1'b1, 1'b0, 10'd3), 0);
    send_item(make_item(RD, 64'h0, 1'b0, 1'b0, 10'd4), 0);
    send_item(make_item(RD, 64'h0, 1'b0, 1'b0, 10'd5), 0);
    send_item(make_item(ENC, 64'h1, 1'b1, 1'b1, 10'h3FF), 0);
    drain();
    sent_vals = {sent_vals, 64'h0};
    sent_vals = {sent_vals, 64'hFFFF_FFFF_FFFF_FFFF};
    sent_vals = {sent_vals, 64'hAAAA_AAAA_AAAA_AAAA};
    sent_vals = {sent_vals, 64'h5555_5555_5555_5555};

    // Random: mostly fresh values until the dictionary fills, then hits and full misses.
    for (int round = 0; round < 2; round++) begin
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 85; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 85; end
          default: begin idle_pct = 22; stall_pct = 22; end
        endcase
        for (int n = 0; n < PHASE_LEN; n++) begin
          r = $urandom_range(99);
          v = {$urandom, $urandom};
          it = make_item(ENC, v, 1'b1, ($urandom_range(7) == 0), 10'($urandom));
          if (r < 8) begin
            it.mode = RD;
            it.present = 1'($urandom);
            if (sb.used > 0 && $urandom_range(9) < 7)
              it.read_index = 10'($urandom_range(sb.used - 1));
          end else if (r < 12) begin
            it.present = 1'b0;
          end else begin
            new_pct = (sb.used < DEPTH) ? 85 : 45;
            if ($urandom_range(99) >= new_pct && sent_vals.size() != 0)
              it.row_value = sent_vals[$urandom_range(sent_vals.size() - 1)];
            else if ($urandom_range(7) == 0)
              it.row_value = 64'($urandom_range(15));
            sent_vals = {sent_vals, it.row_value};
          end
          send_item(it, idle_pct);
        end
        drain();
      end
    end

    item_valid <= 1'b0;
    stall_pct = 0;
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
